// ===== rtl/mm4_pkg.sv =====
package mm4_pkg;

   localparam int DIM               = 4;
   localparam int ROW_W             = 2;
   localparam int DATA_W            = 32;
   localparam int PROD_W            = 2 * DATA_W;
   // Four full products summed without loss need two extra bits.
   localparam int SUM_W             = PROD_W + 2;
   localparam int FRAC_BITS_DEFAULT = 16;

   localparam logic [ROW_W-1:0] FIRST_ROW = ROW_W'(0);
   localparam logic [ROW_W-1:0] LAST_ROW  = ROW_W'(DIM - 1);

   typedef logic [DATA_W-1:0] data_type;
   typedef data_type [DIM-1:0] vec_type;
   typedef logic [PROD_W-1:0] prod_type;
   typedef logic [SUM_W-1:0] sum_type;
   typedef sum_type [DIM-1:0] sum_vec_type;

   typedef struct packed {
      logic             valid;
      logic [ROW_W-1:0] row;
   } tag_type;

endpackage

// ===== rtl/mm4_lane.sv =====
module mm4_lane (
   input  logic              clock,
   input  logic              advance,
   input  mm4_pkg::vec_type  left_row,
   input  mm4_pkg::vec_type  right_col,
   output mm4_pkg::sum_type  sum_ff
);

   mm4_pkg::prod_type prod_ff [mm4_pkg::DIM];
   mm4_pkg::sum_type  sum_in;

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < mm4_pkg::DIM; a++) begin
            prod_ff[a] <= $signed(left_row[a]) * $signed(right_col[a]);
         end
      end
   end

   always_comb begin
      sum_in = '0;
      for (int a = 0; a < mm4_pkg::DIM; a++) begin
         sum_in = sum_in + mm4_pkg::SUM_W'($signed(prod_ff[a]));
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sum_ff <= sum_in;
      end
   end

endmodule

// ===== rtl/mm4_merge.sv =====
module mm4_merge #(
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  mm4_pkg::tag_type            tag,
   input  mm4_pkg::sum_vec_type        sums,
   input  logic                        rsp_ready,
   output logic                        advance,
   output logic                        rsp_valid,
   output logic [mm4_pkg::ROW_W-1:0]   row,
   output mm4_pkg::vec_type            prod,
   output logic                        last
);

   localparam int HI_W = mm4_pkg::SUM_W - mm4_pkg::DATA_W + 1;

   logic                       valid_ff;
   logic                       valid_in;
   logic [mm4_pkg::ROW_W-1:0]  row_ff;
   logic                       last_ff;
   mm4_pkg::vec_type           prod_ff;
   mm4_pkg::vec_type           prod_in;
   mm4_pkg::sum_vec_type       shifted;

   // The output register frees up when it is empty or its transaction completes.
   assign advance  = !valid_ff || rsp_ready;
   assign valid_in = advance ? tag.valid : valid_ff;

   always_comb begin
      for (int c = 0; c < mm4_pkg::DIM; c++) begin
         shifted[c] = $signed(sums[c]) >>> FRAC_BITS;
         if (shifted[c][mm4_pkg::SUM_W-1 -: HI_W] == '0 ||
             shifted[c][mm4_pkg::SUM_W-1 -: HI_W] == '1) begin
            prod_in[c] = shifted[c][mm4_pkg::DATA_W-1:0];
         end else if (shifted[c][mm4_pkg::SUM_W-1]) begin
            prod_in[c] = {1'b1, {(mm4_pkg::DATA_W-1){1'b0}}};
         end else begin
            prod_in[c] = {1'b0, {(mm4_pkg::DATA_W-1){1'b1}}};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && tag.valid) begin
         row_ff  <= tag.row;
         last_ff <= (tag.row == mm4_pkg::LAST_ROW);
         prod_ff <= prod_in;
      end
   end

   assign rsp_valid = valid_ff;
   assign row       = row_ff;
   assign prod      = prod_ff;
   assign last      = last_ff;

endmodule

// ===== rtl/matrix_multiply_4x4_unit.sv =====
// Multiplies two 4x4 signed Q16.16 matrices. Each transaction loads one row of the left
// and of the right matrix at req_row_index; rows 0 to 2 are stored and give no result,
// and a row 3 transaction stores its row and starts the product, which comes out as
// four result rows in order 0 to 3, rsp_last_row marking row 3. Rows are kept after a
// run, so a later row 3 transaction reuses whatever rows were loaded last; all four
// rows must have been loaded once after reset before the first trigger. Four lanes,
// one per product column, each hold four 32x32 multipliers, so one product row enters
// the two-stage lane pipeline per cycle while the output is not stalled. Each result
// row passes the lane product register, the lane sum register and the merge output
// register in that order, and after the first the rest follow one per cycle when
// rsp_ready stays high; req_ready stays low while the product rows are issued. Sums
// are taken at full width, shifted right by FRAC_BITS with rounding toward minus
// infinity, and saturated to 32 bits.
module matrix_multiply_4x4_unit #(
   parameter int FRAC_BITS = mm4_pkg::FRAC_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic        [mm4_pkg::ROW_W-1:0]   req_row_index,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_e0,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_e1,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_e2,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_left_e3,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_e0,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_e1,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_e2,
   input  logic signed [mm4_pkg::DATA_W-1:0]  req_right_e3,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic        [mm4_pkg::ROW_W-1:0]   rsp_out_row,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_prod_e0,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_prod_e1,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_prod_e2,
   output logic signed [mm4_pkg::DATA_W-1:0]  rsp_prod_e3,
   output logic                               rsp_last_row
);

   mm4_pkg::vec_type            left_ff [mm4_pkg::DIM];
   mm4_pkg::vec_type            right_ff [mm4_pkg::DIM];
   mm4_pkg::vec_type            req_left;
   mm4_pkg::vec_type            req_right;
   mm4_pkg::vec_type            left_row;
   mm4_pkg::vec_type            right_col [mm4_pkg::DIM];
   mm4_pkg::sum_vec_type        sums;
   mm4_pkg::vec_type            prod;

   logic                        req_accept;
   logic                        advance;
   logic                        busy_ff;
   logic                        busy_in;
   logic [mm4_pkg::ROW_W-1:0]   issue_row_ff;
   logic [mm4_pkg::ROW_W-1:0]   issue_row_in;
   logic [mm4_pkg::ROW_W-1:0]   tag2_next_row;
   mm4_pkg::tag_type            issue_tag;
   mm4_pkg::tag_type            tag1_ff;
   mm4_pkg::tag_type            tag2_ff;

   assign req_left   = {req_left_e3, req_left_e2, req_left_e1, req_left_e0};
   assign req_right  = {req_right_e3, req_right_e2, req_right_e1, req_right_e0};
   assign req_ready  = !busy_ff;
   assign req_accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (req_accept) begin
         left_ff[req_row_index]  <= req_left;
         right_ff[req_row_index] <= req_right;
      end
   end

   // The stores are read only at issue, so new rows may load while the pipeline drains.
   always_comb begin
      busy_in      = busy_ff;
      issue_row_in = issue_row_ff;
      if (req_accept && req_row_index == mm4_pkg::LAST_ROW) begin
         busy_in      = 1'b1;
         issue_row_in = mm4_pkg::FIRST_ROW;
      end else if (busy_ff && advance) begin
         issue_row_in = issue_row_ff + 1'b1;
         if (issue_row_ff == mm4_pkg::LAST_ROW) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         issue_row_ff <= mm4_pkg::FIRST_ROW;
         tag1_ff      <= '0;
         tag2_ff      <= '0;
      end else begin
         busy_ff      <= busy_in;
         issue_row_ff <= issue_row_in;
         if (advance) begin
            tag1_ff <= issue_tag;
            tag2_ff <= tag1_ff;
         end
      end
   end

   assign issue_tag.valid = busy_ff;
   assign issue_tag.row   = issue_row_ff;
   assign left_row        = left_ff[issue_row_ff];
   assign tag2_next_row   = tag2_ff.row + 1'b1;

   for (genvar c = 0; c < mm4_pkg::DIM; c++) begin : g_lane
      for (genvar a = 0; a < mm4_pkg::DIM; a++) begin : g_col
         assign right_col[c][a] = right_ff[a][c];
      end

      mm4_lane u_lane (
         .clock     (clock),
         .advance   (advance),
         .left_row  (left_row),
         .right_col (right_col[c]),
         .sum_ff    (sums[c])
      );
   end

   mm4_merge #(
      .FRAC_BITS (FRAC_BITS)
   ) u_merge (
      .clock     (clock),
      .reset     (reset),
      .tag       (tag2_ff),
      .sums      (sums),
      .rsp_ready (rsp_ready),
      .advance   (advance),
      .rsp_valid (rsp_valid),
      .row       (rsp_out_row),
      .prod      (prod),
      .last      (rsp_last_row)
   );

   assign rsp_prod_e0 = prod[0];
   assign rsp_prod_e1 = prod[1];
   assign rsp_prod_e2 = prod[2];
   assign rsp_prod_e3 = prod[3];

   a_trigger_starts_run : assert property (@(posedge clock) disable iff (reset)
      req_accept && req_row_index == mm4_pkg::LAST_ROW
      |=> busy_ff && issue_row_ff == mm4_pkg::FIRST_ROW)
      else $error("row 3 transaction did not start a product run");

   a_run_ends : assert property (@(posedge clock) disable iff (reset)
      busy_ff && advance && issue_row_ff == mm4_pkg::LAST_ROW |=> !busy_ff)
      else $error("issue did not stop after the last product row");

   a_rows_in_order : assert property (@(posedge clock) disable iff (reset)
      tag1_ff.valid && tag2_ff.valid |-> tag1_ff.row == tag2_next_row)
      else $error("product rows out of order in the lane pipeline");

   a_stall_holds_issue : assert property (@(posedge clock) disable iff (reset)
      busy_ff && !advance |=> busy_ff && $stable(issue_row_ff))
      else $error("issue moved while the output was stalled");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;
   import mm4_pkg::*;

   localparam int FRAC       = FRAC_BITS_DEFAULT;
   localparam int MAX_CYCLES = 60000;
   localparam int LONG_HOLD  = 150;

   typedef struct {
      logic [ROW_W-1:0] row;
      vec_type          left;
      vec_type          right;
   } row_load_type;

   typedef struct {
      logic [ROW_W-1:0] row;
      vec_type          elems;
      logic             last;
   } product_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic        [ROW_W-1:0]  req_row_index = '0;
   logic signed [DATA_W-1:0] req_left_e0 = '0;
   logic signed [DATA_W-1:0] req_left_e1 = '0;
   logic signed [DATA_W-1:0] req_left_e2 = '0;
   logic signed [DATA_W-1:0] req_left_e3 = '0;
   logic signed [DATA_W-1:0] req_right_e0 = '0;
   logic signed [DATA_W-1:0] req_right_e1 = '0;
   logic signed [DATA_W-1:0] req_right_e2 = '0;
   logic signed [DATA_W-1:0] req_right_e3 = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic        [ROW_W-1:0]  rsp_out_row;
   logic signed [DATA_W-1:0] rsp_prod_e0;
   logic signed [DATA_W-1:0] rsp_prod_e1;
   logic signed [DATA_W-1:0] rsp_prod_e2;
   logic signed [DATA_W-1:0] rsp_prod_e3;
   logic                     rsp_last_row;

   row_load_type    pending_loads[$];
   product_row_type product_rows[$];

   // Copy of both matrices as the block should hold them.
   logic signed [DATA_W-1:0] left_mat  [DIM][DIM];
   logic signed [DATA_W-1:0] right_mat [DIM][DIM];

   logic         idle_on      = 1'b0;
   logic         random_phase = 1'b0;
   logic         hold_done    = 1'b0;
   int unsigned  req_gap      = 0;
   int unsigned  rsp_gap      = 0;
   int unsigned  mismatch_count = 0;
   int unsigned  cycle_count  = 0;
   row_load_type next_load;
   product_row_type got_row;

   matrix_multiply_4x4_unit #(
      .FRAC_BITS(FRAC)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_row_index(req_row_index),
      .req_left_e0(req_left_e0),
      .req_left_e1(req_left_e1),
      .req_left_e2(req_left_e2),
      .req_left_e3(req_left_e3),
      .req_right_e0(req_right_e0),
      .req_right_e1(req_right_e1),
      .req_right_e2(req_right_e2),
      .req_right_e3(req_right_e3),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_row(rsp_out_row),
      .rsp_prod_e0(rsp_prod_e0),
      .rsp_prod_e1(rsp_prod_e1),
      .rsp_prod_e2(rsp_prod_e2),
      .rsp_prod_e3(rsp_prod_e3),
      .rsp_last_row(rsp_last_row)
   );

   always #10 clock = ~clock;

   // One element of the product: exact sum of four 64-bit products, floor shift,
   // then saturation to the 32-bit range.
   function automatic data_type dot_q16(int r, int c);
      logic signed [DATA_W-1:0] a;
      logic signed [DATA_W-1:0] b;
      logic signed [PROD_W-1:0] p;
      logic signed [SUM_W-1:0]  acc;
      acc = '0;
      for (int k = 0; k < DIM; k++) begin
         a = left_mat[r][k];
         b = right_mat[k][c];
         p = a * b;
         acc = acc + p;
      end
      acc = acc >>> FRAC;
      if (acc[SUM_W-1:DATA_W-1] == '0 || acc[SUM_W-1:DATA_W-1] == '1) begin
         return acc[DATA_W-1:0];
      end
      return acc[SUM_W-1] ? 32'h8000_0000 : 32'h7FFF_FFFF;
   endfunction

   task automatic load_and_multiply(logic [ROW_W-1:0] row, vec_type left, vec_type right);
      product_row_type pr;
      for (int c = 0; c < DIM; c++) begin
         left_mat[row][c]  = left[c];
         right_mat[row][c] = right[c];
      end
      if (row == LAST_ROW) begin
         for (int r = 0; r < DIM; r++) begin
            pr.row  = ROW_W'(r);
            for (int c = 0; c < DIM; c++) begin
               pr.elems[c] = dot_q16(r, c);
            end
            pr.last = (r == DIM - 1);
            product_rows.push_back(pr);
         end
      end
   endtask

   // Driver: a new transaction is offered only when the channel is free.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready) begin
            load_and_multiply(req_row_index,
                              {req_left_e3, req_left_e2, req_left_e1, req_left_e0},
                              {req_right_e3, req_right_e2, req_right_e1, req_right_e0});
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
               req_gap   <= $urandom_range(0, 12);
               req_valid <= 1'b0;
            end else if (pending_loads.size() != 0) begin
               next_load = pending_loads.pop_front();
               req_valid     <= 1'b1;
               req_row_index <= next_load.row;
               req_left_e0   <= next_load.left[0];
               req_left_e1   <= next_load.left[1];
               req_left_e2   <= next_load.left[2];
               req_left_e3   <= next_load.left[3];
               req_right_e0  <= next_load.right[0];
               req_right_e1  <= next_load.right[1];
               req_right_e2  <= next_load.right[2];
               req_right_e3  <= next_load.right[3];
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver: one long hold early in the random phase, short random stalls while idle_on is set.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (random_phase && !hold_done) begin
         hold_done <= 1'b1;
         rsp_gap   <= LONG_HOLD;
         rsp_ready <= 1'b0;
      end else if (rsp_gap != 0) begin
         rsp_gap   <= rsp_gap - 1;
         rsp_ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
         rsp_gap   <= $urandom_range(0, 12);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   task automatic report_mismatch(string what);
      mismatch_count++;
      if (mismatch_count <= 10) begin
         $display("mismatch at %0t: %s", $realtime, what);
      end
   endtask

   // Monitor: each product row is checked against the oldest expectation.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (product_rows.size() == 0) begin
            report_mismatch($sformatf("unexpected row %0d", rsp_out_row));
         end else begin
            got_row = product_rows.pop_front();
            if (rsp_out_row !== got_row.row || rsp_last_row !== got_row.last ||
                {rsp_prod_e3, rsp_prod_e2, rsp_prod_e1, rsp_prod_e0} !== got_row.elems) begin
               report_mismatch($sformatf(
                  "expected row %0d last %0b %h %h %h %h, got row %0d last %0b %h %h %h %h",
                  got_row.row, got_row.last, got_row.elems[0], got_row.elems[1],
                  got_row.elems[2], got_row.elems[3], rsp_out_row, rsp_last_row,
                  rsp_prod_e0, rsp_prod_e1, rsp_prod_e2, rsp_prod_e3));
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == MAX_CYCLES) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   function automatic void queue_load(int row, vec_type left, vec_type right);
      row_load_type ld;
      ld.row   = ROW_W'(row);
      ld.left  = left;
      ld.right = right;
      pending_loads.push_back(ld);
   endfunction

   function automatic data_type random_element();
      data_type specials[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                32'h8000_0000, 32'h0001_0000};
      case ($urandom_range(0, 9))
         0, 1, 2, 3: return $urandom;
         4, 5, 6: return data_type'($urandom_range(0, 32'h0020_0000)) - 32'h0010_0000;
         7: return specials[$urandom_range(0, 5)];
         default: return data_type'($urandom_range(0, 32'h0200_0000)) - 32'h0100_0000;
      endcase
   endfunction

   function automatic vec_type random_vec();
      vec_type v;
      for (int i = 0; i < DIM; i++) begin
         v[i] = random_element();
      end
      return v;
   endfunction

   // Mostly full matrix loads with rows 0 to 2 in shuffled order and row 3 last, sometimes
   // with a row left stale or loaded twice; the rest are lone loads of any row.
   function automatic int queue_random_batch();
      int order[3] = '{0, 1, 2};
      int j;
      int tmp;
      int count = 0;
      if ($urandom_range(0, 4) == 0) begin
         queue_load($urandom_range(0, 3), random_vec(), random_vec());
         return 1;
      end
      for (int i = 2; i > 0; i--) begin
         j = $urandom_range(0, i);
         tmp = order[i];
         order[i] = order[j];
         order[j] = tmp;
      end
      for (int i = 0; i < 3; i++) begin
         if ($urandom_range(0, 7) != 0) begin
            queue_load(order[i], random_vec(), random_vec());
            count++;
         end
         if ($urandom_range(0, 9) == 0) begin
            queue_load(order[i], random_vec(), random_vec());
            count++;
         end
      end
      queue_load(LAST_ROW, random_vec(), random_vec());
      return count + 1;
   endfunction

   task automatic wait_until_drained();
      @(negedge clock);
      while (pending_loads.size() != 0 || req_valid || product_rows.size() != 0) begin
         @(negedge clock);
      end
   endtask

   initial begin
      vec_type pos_max;
      vec_type neg_max;
      vec_type all_ones;
      vec_type one_q16;
      int items;
      pos_max  = {DIM{32'h7FFF_FFFF}};
      neg_max  = {DIM{32'h8000_0000}};
      all_ones = {DIM{32'hFFFF_FFFF}};
      one_q16  = {DIM{32'h0001_0000}};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Largest positive operands everywhere: every sum saturates high.
      for (int r = 0; r < DIM; r++) begin
         queue_load(r, pos_max, pos_max);
      end
      // Most negative operands: each sum is exactly 2^64 and needs the full width.
      for (int r = 0; r < DIM; r++) begin
         queue_load(r, neg_max, neg_max);
      end
      // Left all negative, right all positive: saturates low.
      for (int r = 0; r < DIM; r++) begin
         queue_load(r, neg_max, pos_max);
      end
      // Identity on the left in shuffled order: the product must equal the right
      // matrix, including both range limits exactly.
      queue_load(2, {32'h0, 32'h0001_0000, 32'h0, 32'h0},
                 {32'h0, 32'h1, 32'h8000_0000, 32'h7FFF_FFFF});
      queue_load(0, {32'h0, 32'h0, 32'h0, 32'h0001_0000},
                 {32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 32'h0});
      queue_load(1, {32'h0, 32'h0, 32'h0001_0000, 32'h0}, random_vec());
      queue_load(3, {32'h0001_0000, 32'h0, 32'h0, 32'h0},
                 {32'h1234_5678, 32'hFFFF_0000, 32'h1, 32'h8000_0001});
      // Stale rows: only row 3 changes between these triggers.
      queue_load(3, all_ones, one_q16);
      queue_load(3, '0, '0);
      // Tiny negative sums must round toward minus infinity; row 1 is loaded twice.
      queue_load(1, random_vec(), random_vec());
      queue_load(0, all_ones, one_q16);
      queue_load(2, all_ones, {DIM{32'h1}});
      queue_load(1, all_ones, {DIM{32'h1}});
      queue_load(3, all_ones, {DIM{32'h1}});
      wait_until_drained();

      idle_on      = 1'b1;
      random_phase = 1'b1;
      items = 0;
      while (items < 70) begin
         items += queue_random_batch();
      end
      // The sender holds back here until every product row has been seen.
      wait_until_drained();

      idle_on = 1'b0;
      while (items < 92) begin
         items += queue_random_batch();
      end
      wait_until_drained();
      repeat (20) @(negedge clock);

      if (mismatch_count == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
